>>> hdl/nary_tree_table_traversal_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the n-ary tree table core
// Implication checks, same cycle and next cycle.
// ----------------------------------------------------------------------------
`ifndef NARY_TREE_TABLE_TRAVERSAL_CORE_MACROS_SVH
`define NARY_TREE_TABLE_TRAVERSAL_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define NTT_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define NTT_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/ntt_pkg.sv
// ----------------------------------------------------------------------------
// ntt_pkg
// Types and constants of the n-ary tree table core.
// ----------------------------------------------------------------------------
`default_nettype none

package ntt_pkg;

   localparam int MAX_NODES = 32;
   localparam int SLOT_W    = 6;
   localparam int DEPTH_W   = 5;
   localparam int LABEL_W   = 8;
   localparam int Q_AW      = $clog2(MAX_NODES);

   localparam logic [SLOT_W-1:0]  ROOT_SLOT = SLOT_W'(1);
   localparam logic [SLOT_W-1:0]  NO_SLOT   = '0;
   localparam logic [SLOT_W-1:0]  MAX_SLOT  = SLOT_W'(MAX_NODES);
   localparam logic [DEPTH_W-1:0] DEPTH_CAP = DEPTH_W'(31);

   typedef enum logic [1:0] {
      CMD_CLEAR    = 2'd0,
      CMD_INSERT   = 2'd1,
      CMD_TRAVERSE = 2'd2,
      CMD_LEVEL    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ORD_PRE   = 2'd0,
      ORD_IN    = 2'd1,
      ORD_POST  = 2'd2,
      ORD_LEVEL = 2'd3
   } order_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_EMPTY      = 3'd1,
      ST_BAD_PARENT = 3'd2,
      ST_FULL       = 3'd3,
      ST_NOT_FOUND  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_P,
      S_INS_WP,
      S_INS_RS,
      S_PRE_EMIT,
      S_PRE_UP,
      S_POST_DOWN,
      S_POST_UP,
      S_LV_QRD,
      S_LV_NRD,
      S_LV_VISIT,
      S_LV_CH,
      S_QRY_CMP,
      S_FLUSH
   } state_type;

   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic [SLOT_W-1:0]  fc;
      logic [SLOT_W-1:0]  ns;
      logic [SLOT_W-1:0]  lc;
      logic [SLOT_W-1:0]  par;
      logic [DEPTH_W-1:0] depth;
   } node_type;

endpackage

`default_nettype wire

>>> hdl/nary_tree_table_traversal_core.sv
// Clear, rejected requests, root insert and requests on an empty tree go straight to
// the result; other inserts read the parent, write the new node and the parent, and
// rewrite the old last child too when the parent already has children. The level query
// reads slots in turn from the root until the label or the last slot; output stalls hold
// the walks. One request at a time, taken the cycle after the final result; reset empties
// the tree.
// ----------------------------------------------------------------------------
// nary_tree_table_traversal_core
// First-child/next-sibling tree in a node table with walks and level query.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nary_tree_table_traversal_core_macros.svh"

module nary_tree_table_traversal_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // [7:0] label, [13:8] parent_slot, [15:14] order, [21:16] visit_limit
   input  wire logic [23:0] req_tdata,
   // [1:0] cmd
   input  wire logic [1:0]  req_tuser,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] value, [13:8] node_total, [19:14] leaf_total, [24:20] tree_depth
   output      logic [31:0] rsp_tdata,
   // [2:0] status
   output      logic [2:0]  rsp_tuser,
   output      logic        rsp_tlast
);

   localparam int SW = ntt_pkg::SLOT_W;
   localparam int DW = ntt_pkg::DEPTH_W;
   localparam int LW = ntt_pkg::LABEL_W;
   localparam int QW = ntt_pkg::Q_AW;

   // storage
   ntt_pkg::node_type node_mem [0:ntt_pkg::MAX_NODES];
   logic [SW-1:0]     q_mem    [0:ntt_pkg::MAX_NODES-1];

   ntt_pkg::node_type node_rd_ff;
   logic [SW-1:0]     q_rd_ff;

   logic              node_rd_en, node_wr_en, q_rd_en, q_wr_en;
   logic [SW-1:0]     node_rd_addr, node_wr_addr;
   ntt_pkg::node_type node_wr_data;
   logic [QW-1:0]     q_rd_addr, q_wr_addr;
   logic [SW-1:0]     q_wr_data;

   // control
   ntt_pkg::state_type  state_ff, state_in;
   ntt_pkg::status_type st_ff, st_in;
   logic [SW-1:0]       cur_ff, cur_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [LW-1:0]       pend_label_ff, pend_label_in;
   logic [SW-1:0]       cnt_ff, cnt_in;
   logic [SW-1:0]       leaf_ff, leaf_in;
   logic [DW-1:0]       maxd_ff, maxd_in;
   logic [SW-1:0]       front_ff, front_in, rear_ff, rear_in, lim_ff, lim_in;
   logic [LW-1:0]       lbl_ff, lbl_in;
   ntt_pkg::node_type   pw_ff, pw_in;
   logic                had_child_ff, had_child_in;

   // result register
   logic          rsp_valid_ff;
   logic [31:0]   rsp_data_ff;
   logic [2:0]    rsp_status_ff;
   logic          rsp_last_ff;

   logic          emit_en, emit_last;
   logic [2:0]    emit_status;
   logic [LW-1:0] emit_value;

   logic                out_free, can_visit;
   ntt_pkg::cmd_type    req_cmd;
   ntt_pkg::order_type  req_order;
   logic [LW-1:0]       req_label;
   logic [SW-1:0]       req_parent, req_limit;
   ntt_pkg::node_type   rd;
   logic [DW-1:0]       new_depth;

   assign req_label  = req_tdata[7:0];
   assign req_parent = req_tdata[13:8];
   assign req_order  = ntt_pkg::order_type'(req_tdata[15:14]);
   assign req_limit  = req_tdata[21:16];
   assign req_cmd    = ntt_pkg::cmd_type'(req_tuser);

   assign req_tready = (state_ff == ntt_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   // a visited label is held back one step so the final one can carry tlast
   assign can_visit = !pend_valid_ff || out_free;
   assign rd        = node_rd_ff;
   assign new_depth = (rd.depth == ntt_pkg::DEPTH_CAP) ? ntt_pkg::DEPTH_CAP : rd.depth + 1'b1;

   // ------------------------------------------------------------------------
   // memories
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (node_wr_en) begin
         node_mem[node_wr_addr] <= node_wr_data;
      end
      if (node_rd_en) begin
         node_rd_ff <= node_mem[node_rd_addr];
      end
      if (q_wr_en) begin
         q_mem[q_wr_addr] <= q_wr_data;
      end
      if (q_rd_en) begin
         q_rd_ff <= q_mem[q_rd_addr];
      end
   end

   // ------------------------------------------------------------------------
   // state register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ntt_pkg::S_IDLE;
         pend_valid_ff <= 1'b0;
         cnt_ff        <= '0;
         leaf_ff       <= '0;
         maxd_ff       <= '0;
         front_ff      <= '0;
         rear_ff       <= '0;
         lim_ff        <= ntt_pkg::MAX_SLOT;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         cnt_ff        <= cnt_in;
         leaf_ff       <= leaf_in;
         maxd_ff       <= maxd_in;
         front_ff      <= front_in;
         rear_ff       <= rear_in;
         lim_ff        <= lim_in;
      end
      st_ff         <= st_in;
      cur_ff        <= cur_in;
      pend_label_ff <= pend_label_in;
      lbl_ff        <= lbl_in;
      pw_ff         <= pw_in;
      had_child_ff  <= had_child_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit_en) begin
         rsp_data_ff   <= {7'd0, maxd_ff, leaf_ff, cnt_ff, emit_value};
         rsp_status_ff <= emit_status;
         rsp_last_ff   <= emit_last;
      end
   end

   // ------------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      st_in         = st_ff;
      cur_in        = cur_ff;
      pend_valid_in = pend_valid_ff;
      pend_label_in = pend_label_ff;
      cnt_in        = cnt_ff;
      leaf_in       = leaf_ff;
      maxd_in       = maxd_ff;
      front_in      = front_ff;
      rear_in       = rear_ff;
      lim_in        = lim_ff;
      lbl_in        = lbl_ff;
      pw_in         = pw_ff;
      had_child_in  = had_child_ff;

      node_rd_en   = 1'b0;
      node_rd_addr = cur_ff;
      node_wr_en   = 1'b0;
      node_wr_addr = cur_ff;
      node_wr_data = pw_ff;
      q_rd_en      = 1'b0;
      q_rd_addr    = front_ff[QW-1:0];
      q_wr_en      = 1'b0;
      q_wr_addr    = rear_ff[QW-1:0];
      q_wr_data    = ntt_pkg::ROOT_SLOT;

      emit_en     = 1'b0;
      emit_last   = 1'b0;
      emit_status = ntt_pkg::ST_OK;
      emit_value  = pend_label_ff;

      unique case (state_ff)
         ntt_pkg::S_IDLE: begin
            if (req_tvalid) begin
               lbl_in        = req_label;
               pend_label_in = '0;
               st_in         = ntt_pkg::ST_OK;
               state_in      = ntt_pkg::S_FLUSH;
               unique case (req_cmd)
                  ntt_pkg::CMD_CLEAR: begin
                     cnt_in  = '0;
                     leaf_in = '0;
                     maxd_in = '0;
                  end
                  ntt_pkg::CMD_INSERT: begin
                     priority if (req_label == '0) begin
                        st_in = ntt_pkg::ST_BAD_PARENT;
                     end else if (cnt_ff == '0) begin
                        node_wr_en   = 1'b1;
                        node_wr_addr = ntt_pkg::ROOT_SLOT;
                        node_wr_data = '{label: req_label, fc: ntt_pkg::NO_SLOT,
                                         ns: ntt_pkg::NO_SLOT, lc: ntt_pkg::NO_SLOT,
                                         par: ntt_pkg::NO_SLOT, depth: '0};
                        cnt_in  = ntt_pkg::ROOT_SLOT;
                        leaf_in = SW'(1);
                        maxd_in = '0;
                     end else if (cnt_ff >= ntt_pkg::MAX_SLOT) begin
                        st_in = ntt_pkg::ST_FULL;
                     end else if (req_parent == '0 || req_parent > cnt_ff) begin
                        st_in = ntt_pkg::ST_BAD_PARENT;
                     end else begin
                        cur_in       = req_parent;
                        node_rd_en   = 1'b1;
                        node_rd_addr = req_parent;
                        state_in     = ntt_pkg::S_INS_P;
                     end
                  end
                  ntt_pkg::CMD_TRAVERSE, ntt_pkg::CMD_LEVEL: begin
                     priority if (cnt_ff == '0) begin
                        st_in = ntt_pkg::ST_EMPTY;
                     end else if (req_cmd == ntt_pkg::CMD_LEVEL) begin
                        if (req_label != '0) begin
                           cur_in       = ntt_pkg::ROOT_SLOT;
                           node_rd_en   = 1'b1;
                           node_rd_addr = ntt_pkg::ROOT_SLOT;
                           state_in     = ntt_pkg::S_QRY_CMP;
                        end else begin
                           st_in = ntt_pkg::ST_NOT_FOUND;
                        end
                     end else begin
                        cur_in       = ntt_pkg::ROOT_SLOT;
                        node_rd_addr = ntt_pkg::ROOT_SLOT;
                        unique case (req_order)
                           ntt_pkg::ORD_PRE: begin
                              node_rd_en = 1'b1;
                              state_in   = ntt_pkg::S_PRE_EMIT;
                           end
                           // both give children left to right, each node after its subtree
                           ntt_pkg::ORD_IN, ntt_pkg::ORD_POST: begin
                              node_rd_en = 1'b1;
                              state_in   = ntt_pkg::S_POST_DOWN;
                           end
                           ntt_pkg::ORD_LEVEL: begin
                              q_wr_en   = 1'b1;
                              q_wr_addr = '0;
                              front_in  = '0;
                              rear_in   = SW'(1);
                              lim_in    = (req_limit == '0 || req_limit > ntt_pkg::MAX_SLOT)
                                          ? ntt_pkg::MAX_SLOT : req_limit;
                              state_in  = ntt_pkg::S_LV_QRD;
                           end
                           default: ;
                        endcase
                     end
                  end
                  default: ;
               endcase
            end
         end

         // parent entry in rd; new slot is cnt+1
         ntt_pkg::S_INS_P: begin
            node_wr_en   = 1'b1;
            node_wr_addr = cnt_ff + 1'b1;
            node_wr_data = '{label: lbl_ff, fc: ntt_pkg::NO_SLOT, ns: ntt_pkg::NO_SLOT,
                             lc: ntt_pkg::NO_SLOT, par: cur_ff, depth: new_depth};
            pw_in        = rd;
            pw_in.lc     = cnt_ff + 1'b1;
            had_child_in = (rd.fc != ntt_pkg::NO_SLOT);
            if (rd.fc == ntt_pkg::NO_SLOT) begin
               pw_in.fc = cnt_ff + 1'b1;
            end else begin
               leaf_in = leaf_ff + 1'b1;
            end
            if (new_depth > maxd_ff) begin
               maxd_in = new_depth;
            end
            cnt_in   = cnt_ff + 1'b1;
            state_in = ntt_pkg::S_INS_WP;
         end

         ntt_pkg::S_INS_WP: begin
            node_wr_en = 1'b1;
            if (had_child_ff) begin
               node_rd_en   = 1'b1;
               node_rd_addr = rd.lc;   // old last child, read before parent was rewritten
               cur_in       = rd.lc;
               state_in     = ntt_pkg::S_INS_RS;
            end else begin
               state_in = ntt_pkg::S_FLUSH;
            end
         end

         ntt_pkg::S_INS_RS: begin
            node_wr_en   = 1'b1;
            node_wr_addr = cur_ff;
            node_wr_data = rd;
            node_wr_data.ns = cnt_ff;
            state_in     = ntt_pkg::S_FLUSH;
         end

         ntt_pkg::S_PRE_EMIT: begin
            if (can_visit) begin
               emit_en       = pend_valid_ff;
               pend_valid_in = 1'b1;
               pend_label_in = rd.label;
               node_rd_en    = 1'b1;
               priority if (rd.fc != ntt_pkg::NO_SLOT) begin
                  cur_in       = rd.fc;
                  node_rd_addr = rd.fc;
               end else if (cur_ff == ntt_pkg::ROOT_SLOT) begin
                  node_rd_en = 1'b0;
                  state_in   = ntt_pkg::S_FLUSH;
               end else if (rd.ns != ntt_pkg::NO_SLOT) begin
                  cur_in       = rd.ns;
                  node_rd_addr = rd.ns;
               end else begin
                  cur_in       = rd.par;
                  node_rd_addr = rd.par;
                  state_in     = ntt_pkg::S_PRE_UP;
               end
            end
         end

         ntt_pkg::S_PRE_UP: begin
            node_rd_en = 1'b1;
            priority if (cur_ff == ntt_pkg::ROOT_SLOT) begin
               node_rd_en = 1'b0;
               state_in   = ntt_pkg::S_FLUSH;
            end else if (rd.ns != ntt_pkg::NO_SLOT) begin
               cur_in       = rd.ns;
               node_rd_addr = rd.ns;
               state_in     = ntt_pkg::S_PRE_EMIT;
            end else begin
               cur_in       = rd.par;
               node_rd_addr = rd.par;
            end
         end

         ntt_pkg::S_POST_DOWN, ntt_pkg::S_POST_UP: begin
            if (state_ff == ntt_pkg::S_POST_DOWN && rd.fc != ntt_pkg::NO_SLOT) begin
               node_rd_en   = 1'b1;
               cur_in       = rd.fc;
               node_rd_addr = rd.fc;
            end else if (can_visit) begin
               emit_en       = pend_valid_ff;
               pend_valid_in = 1'b1;
               pend_label_in = rd.label;
               node_rd_en    = 1'b1;
               priority if (cur_ff == ntt_pkg::ROOT_SLOT) begin
                  node_rd_en = 1'b0;
                  state_in   = ntt_pkg::S_FLUSH;
               end else if (rd.ns != ntt_pkg::NO_SLOT) begin
                  cur_in       = rd.ns;
                  node_rd_addr = rd.ns;
                  state_in     = ntt_pkg::S_POST_DOWN;
               end else begin
                  cur_in       = rd.par;
                  node_rd_addr = rd.par;
                  state_in     = ntt_pkg::S_POST_UP;
               end
            end
         end

         ntt_pkg::S_LV_QRD: begin
            if (front_ff < lim_ff && front_ff < rear_ff) begin
               q_rd_en  = 1'b1;
               front_in = front_ff + 1'b1;
               state_in = ntt_pkg::S_LV_NRD;
            end else begin
               state_in = ntt_pkg::S_FLUSH;
            end
         end

         ntt_pkg::S_LV_NRD: begin
            node_rd_en   = 1'b1;
            node_rd_addr = q_rd_ff;
            cur_in       = q_rd_ff;
            state_in     = ntt_pkg::S_LV_VISIT;
         end

         ntt_pkg::S_LV_VISIT: begin
            if (can_visit) begin
               emit_en       = pend_valid_ff;
               pend_valid_in = 1'b1;
               pend_label_in = rd.label;
               if (rd.fc != ntt_pkg::NO_SLOT && rear_ff < lim_ff) begin
                  q_wr_en      = 1'b1;
                  q_wr_data    = rd.fc;
                  rear_in      = rear_ff + 1'b1;
                  node_rd_en   = 1'b1;
                  node_rd_addr = rd.fc;
                  state_in     = ntt_pkg::S_LV_CH;
               end else begin
                  state_in = ntt_pkg::S_LV_QRD;
               end
            end
         end

         ntt_pkg::S_LV_CH: begin
            if (rd.ns != ntt_pkg::NO_SLOT && rear_ff < lim_ff) begin
               q_wr_en      = 1'b1;
               q_wr_data    = rd.ns;
               rear_in      = rear_ff + 1'b1;
               node_rd_en   = 1'b1;
               node_rd_addr = rd.ns;
            end else begin
               state_in = ntt_pkg::S_LV_QRD;
            end
         end

         ntt_pkg::S_QRY_CMP: begin
            priority if (rd.label == lbl_ff) begin
               st_in         = ntt_pkg::ST_OK;
               pend_label_in = {{(LW-DW){1'b0}}, rd.depth};
               state_in      = ntt_pkg::S_FLUSH;
            end else if (cur_ff == cnt_ff) begin
               st_in         = ntt_pkg::ST_NOT_FOUND;
               pend_label_in = '0;
               state_in      = ntt_pkg::S_FLUSH;
            end else begin
               cur_in       = cur_ff + 1'b1;
               node_rd_en   = 1'b1;
               node_rd_addr = cur_ff + 1'b1;
            end
         end

         ntt_pkg::S_FLUSH: begin
            if (out_free) begin
               emit_en       = 1'b1;
               emit_last     = 1'b1;
               emit_status   = st_ff;
               emit_value    = pend_label_ff;
               pend_valid_in = 1'b0;
               state_in      = ntt_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = ntt_pkg::S_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------------
   `NTT_ASSERT_IMP(a_idle_no_pend, clock, reset, state_ff == ntt_pkg::S_IDLE, !pend_valid_ff, "label held back while idle")
   `NTT_ASSERT_IMP(a_counts, clock, reset, 1'b1, cnt_ff <= ntt_pkg::MAX_SLOT && leaf_ff <= cnt_ff, "node or leaf count out of range")
   `NTT_ASSERT_NXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, state_ff != ntt_pkg::S_IDLE, "request taken without work")
   `NTT_ASSERT_IMP(a_queue, clock, reset, state_ff == ntt_pkg::S_LV_QRD || state_ff == ntt_pkg::S_LV_CH, rear_ff <= lim_ff && front_ff <= rear_ff, "level queue pointers out of order")

endmodule

`default_nettype wire

>>> dv/nary_tree_table_traversal_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nary_tree_table_traversal_core_tb
// Drives clear, insert, traverse and level-query requests into the tree core
// and checks every response against a behavioural tree kept in the bench.
// ----------------------------------------------------------------------------

module nary_tree_table_traversal_core_tb;

   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      ntt_pkg::status_type status;
      logic [7:0]          value;
      logic                last;
      logic [5:0]          node_total;
      logic [5:0]          leaf_total;
      logic [4:0]          tree_depth;
   } tree_rsp_type;

   typedef struct {
      ntt_pkg::cmd_type    cmd;
      logic [7:0]          label;
      logic [5:0]          parent_slot;
      ntt_pkg::order_type  order;
      logic [5:0]          visit_limit;
      bit                  has_rsp;
      tree_rsp_type        rsp;
   } tree_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   nary_tree_table_traversal_core DUT (.*);

   always #5 clock = ~clock;

   // behavioural tree, slots 1..MAX_NODES
   logic [7:0] t_label [ntt_pkg::MAX_NODES+1];
   logic [5:0] t_fc [ntt_pkg::MAX_NODES+1];
   logic [5:0] t_ns [ntt_pkg::MAX_NODES+1];
   logic [5:0] t_lc [ntt_pkg::MAX_NODES+1];
   logic [4:0] t_depth [ntt_pkg::MAX_NODES+1];
   int         t_nodes, t_leaves, t_maxd;

   tree_rsp_type expected_rsp [$];
   int        errors = 0;
   int        rsp_seen = 0;
   int        cycles = 0;
   int        send_idle_pct = 18, recv_idle_pct = 53;
   bit        hold_rsp = 1'b0;
   int        ok_walks = 0, inserts_ok = 0;

   function automatic tree_rsp_type mk_rsp(ntt_pkg::status_type st, logic [7:0] v);
      tree_rsp_type r;
      r.status = st; r.value = v; r.last = 1'b0;
      r.node_total = 6'(t_nodes); r.leaf_total = 6'(t_leaves);
      r.tree_depth = 5'(t_maxd);
      return r;
   endfunction

   function automatic ntt_pkg::status_type tree_insert(logic [7:0] lab, int p);
      int s, d;
      if (lab == 0) return ntt_pkg::ST_BAD_PARENT;
      if (t_nodes == 0) begin
         t_label[1] = lab; t_fc[1] = 0; t_ns[1] = 0; t_lc[1] = 0; t_depth[1] = 0;
         t_nodes = 1; t_leaves = 1; t_maxd = 0;
         return ntt_pkg::ST_OK;
      end
      if (t_nodes >= ntt_pkg::MAX_NODES) return ntt_pkg::ST_FULL;
      if (p < 1 || p > t_nodes) return ntt_pkg::ST_BAD_PARENT;
      s = t_nodes + 1;
      t_label[s] = lab; t_fc[s] = 0; t_ns[s] = 0; t_lc[s] = 0;
      if (t_fc[p] == 0) t_fc[p] = 6'(s);
      else begin
         t_ns[t_lc[p]] = 6'(s);
         t_leaves++;
      end
      t_lc[p] = 6'(s);
      d = t_depth[p] + 1;
      if (d > 31) d = 31;
      t_depth[s] = 5'(d);
      if (d > t_maxd) t_maxd = d;
      t_nodes = s;
      return ntt_pkg::ST_OK;
   endfunction

   task automatic predict_tree(input tree_req_type r);
      tree_rsp_type        out [$];
      int                  stk [$];
      int                  tmp [$];
      int                  cur, i, lim, front;
      ntt_pkg::status_type st;
      logic [7:0]          v;
      case (r.cmd)
         ntt_pkg::CMD_CLEAR: begin
            t_nodes = 0; t_leaves = 0; t_maxd = 0;
            out.push_back(mk_rsp(ntt_pkg::ST_OK, 0));
         end
         ntt_pkg::CMD_INSERT: begin
            st = tree_insert(r.label, r.parent_slot);
            if (st == ntt_pkg::ST_OK) inserts_ok++;
            out.push_back(mk_rsp(st, 0));
         end
         default: begin
            if (t_nodes == 0) out.push_back(mk_rsp(ntt_pkg::ST_EMPTY, 0));
            else if (r.cmd == ntt_pkg::CMD_LEVEL) begin
               st = ntt_pkg::ST_NOT_FOUND; v = 0;
               if (r.label != 0)
                  for (i = 1; i <= t_nodes; i++)
                     if (t_label[i] == r.label) begin
                        st = ntt_pkg::ST_OK; v = 8'(t_depth[i]);
                        break;
                     end
               out.push_back(mk_rsp(st, v));
            end else begin
               ok_walks++;
               case (r.order)
                  ntt_pkg::ORD_PRE: begin
                     stk.push_back(1);
                     while (stk.size() > 0) begin
                        cur = stk.pop_back();
                        out.push_back(mk_rsp(ntt_pkg::ST_OK, t_label[cur]));
                        tmp.delete();
                        for (i = t_fc[cur]; i != 0; i = t_ns[i]) tmp.push_back(i);
                        while (tmp.size() > 0) stk.push_back(tmp.pop_back());
                     end
                  end
                  ntt_pkg::ORD_IN: begin
                     cur = 1;
                     while (cur != 0 || stk.size() > 0) begin
                        while (cur != 0) begin
                           stk.push_back(cur);
                           cur = t_fc[cur];
                        end
                        cur = stk.pop_back();
                        out.push_back(mk_rsp(ntt_pkg::ST_OK, t_label[cur]));
                        cur = t_ns[cur];
                     end
                  end
                  ntt_pkg::ORD_POST: begin
                     stk.push_back(1);
                     while (stk.size() > 0) begin
                        cur = stk.pop_back();
                        tmp.push_back(cur);
                        for (i = t_fc[cur]; i != 0; i = t_ns[i]) stk.push_back(i);
                     end
                     while (tmp.size() > 0)
                        out.push_back(mk_rsp(ntt_pkg::ST_OK, t_label[tmp.pop_back()]));
                  end
                  default: begin
                     lim = r.visit_limit;
                     if (lim == 0 || lim > ntt_pkg::MAX_NODES) lim = ntt_pkg::MAX_NODES;
                     tmp.push_back(1);
                     front = 0;
                     while (front < lim && front < tmp.size()) begin
                        cur = tmp[front++];
                        out.push_back(mk_rsp(ntt_pkg::ST_OK, t_label[cur]));
                        for (i = t_fc[cur]; i != 0 && tmp.size() < lim; i = t_ns[i])
                           tmp.push_back(i);
                     end
                  end
               endcase
            end
         end
      endcase
      out[out.size()-1].last = 1'b1;
      if (r.has_rsp && out.size() == 1 && out[0] != r.rsp) begin
         $error("directed row: typed response %h differs from prediction %h",
                r.rsp, out[0]);
         errors++;
      end
      foreach (out[k]) expected_rsp.push_back(out[k]);
   endtask

   task automatic send_req(input tree_req_type r);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.cmd;
      req_tdata  <= {2'b0, r.visit_limit, r.order, r.parent_slot, r.label};
      do @(posedge clock); while (!req_tready);
      predict_tree(r);
   endtask

   function automatic tree_req_type mk_req(ntt_pkg::cmd_type c, logic [7:0] lab,
                                           logic [5:0] p, ntt_pkg::order_type o,
                                           logic [5:0] lim);
      tree_req_type r;
      r.cmd = c; r.label = lab; r.parent_slot = p; r.order = o; r.visit_limit = lim;
      r.has_rsp = 1'b0; r.rsp = '0;
      return r;
   endfunction

   function automatic tree_req_type rand_req();
      int k;
      tree_req_type r;
      k = $urandom_range(99);
      r = mk_req(ntt_pkg::CMD_INSERT, 8'($urandom_range(1, 255)),
                 6'($urandom_range(1, t_nodes > 0 ? t_nodes : 1)),
                 ntt_pkg::order_type'($urandom_range(3)), 6'($urandom_range(63)));
      if (k < 3) r.cmd = ntt_pkg::CMD_CLEAR;
      else if (k < 45) begin
         // mostly valid parents, some noise
         if ($urandom_range(9) == 0) r.parent_slot = 6'($urandom_range(63));
         if ($urandom_range(29) == 0) r.label = 0;
      end else if (k < 80) r.cmd = ntt_pkg::CMD_TRAVERSE;
      else begin
         r.cmd = ntt_pkg::CMD_LEVEL;
         if ($urandom_range(19) == 0) r.label = 0;
      end
      return r;
   endfunction

   task automatic drain_rsp();
      req_tvalid <= 1'b0;
      while (expected_rsp.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // response side
   always @(posedge clock) begin
      tree_rsp_type got, exp_r;
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = ntt_pkg::status_type'(rsp_tuser);
         got.value = rsp_tdata[7:0];
         got.last = rsp_tlast;
         got.node_total = rsp_tdata[13:8];
         got.leaf_total = rsp_tdata[19:14];
         got.tree_depth = rsp_tdata[24:20];
         rsp_seen <= rsp_seen + 1;
         if (expected_rsp.size() == 0) begin
            $error("unexpected response %h", got);
            errors++;
         end else begin
            exp_r = expected_rsp.pop_front();
            if (got.status !== exp_r.status) begin
               $error("status: expected %0d got %0d", exp_r.status, got.status); errors++;
            end
            if (got.value !== exp_r.value) begin
               $error("value: expected %0d got %0d", exp_r.value, got.value); errors++;
            end
            if (got.last !== exp_r.last) begin
               $error("last: expected %0d got %0d", exp_r.last, got.last); errors++;
            end
            if (got.node_total !== exp_r.node_total) begin
               $error("node_total: expected %0d got %0d", exp_r.node_total,
                      got.node_total); errors++;
            end
            if (got.leaf_total !== exp_r.leaf_total) begin
               $error("leaf_total: expected %0d got %0d", exp_r.leaf_total,
                      got.leaf_total); errors++;
            end
            if (got.tree_depth !== exp_r.tree_depth) begin
               $error("tree_depth: expected %0d got %0d", exp_r.tree_depth,
                      got.tree_depth); errors++;
            end
         end
      end
      rsp_tready <= !hold_rsp && !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
   end

   // long receiver hold-off, counted here
   initial begin
      int n;
      wait (inserts_ok > 60);
      hold_rsp = 1'b1;
      for (n = 0; n < 300; n++) @(posedge clock);
      hold_rsp = 1'b0;
   end

   always @(posedge clock)
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end

   initial begin
      tree_req_type dir [$];
      tree_req_type r;
      int i;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows
      r = mk_req(ntt_pkg::CMD_TRAVERSE, 0, 0, ntt_pkg::ORD_PRE, 0); r.has_rsp = 1;
      r.rsp = '{ntt_pkg::ST_EMPTY, 0, 1, 0, 0, 0}; dir.push_back(r);
      r = mk_req(ntt_pkg::CMD_LEVEL, 8'hFF, 0, ntt_pkg::ORD_PRE, 0); r.has_rsp = 1;
      r.rsp = '{ntt_pkg::ST_EMPTY, 0, 1, 0, 0, 0}; dir.push_back(r);
      r = mk_req(ntt_pkg::CMD_INSERT, 0, 1, ntt_pkg::ORD_PRE, 0); r.has_rsp = 1;
      r.rsp = '{ntt_pkg::ST_BAD_PARENT, 0, 1, 0, 0, 0}; dir.push_back(r);
      r = mk_req(ntt_pkg::CMD_INSERT, 8'hFF, 6'h3F, ntt_pkg::ORD_LEVEL, 6'h3F);
      r.has_rsp = 1;
      r.rsp = '{ntt_pkg::ST_OK, 0, 1, 1, 1, 0}; dir.push_back(r);
      r = mk_req(ntt_pkg::CMD_INSERT, 8'h01, 0, ntt_pkg::ORD_PRE, 0); r.has_rsp = 1;
      r.rsp = '{ntt_pkg::ST_BAD_PARENT, 0, 1, 1, 1, 0}; dir.push_back(r);
      r = mk_req(ntt_pkg::CMD_INSERT, 8'h01, 2, ntt_pkg::ORD_PRE, 0); r.has_rsp = 1;
      r.rsp = '{ntt_pkg::ST_BAD_PARENT, 0, 1, 1, 1, 0}; dir.push_back(r);
      dir.push_back(mk_req(ntt_pkg::CMD_INSERT, 8'h55, 1, ntt_pkg::ORD_PRE, 0));
      dir.push_back(mk_req(ntt_pkg::CMD_INSERT, 8'hAA, 1, ntt_pkg::ORD_PRE, 0));
      dir.push_back(mk_req(ntt_pkg::CMD_INSERT, 8'h0F, 2, ntt_pkg::ORD_PRE, 0));
      dir.push_back(mk_req(ntt_pkg::CMD_INSERT, 8'hF0, 4, ntt_pkg::ORD_PRE, 0));
      dir.push_back(mk_req(ntt_pkg::CMD_INSERT, 8'h33, 2, ntt_pkg::ORD_PRE, 0));
      for (i = 0; i < 4; i++)
         dir.push_back(mk_req(ntt_pkg::CMD_TRAVERSE, 0, 0, ntt_pkg::order_type'(i), 0));
      dir.push_back(mk_req(ntt_pkg::CMD_TRAVERSE, 0, 0, ntt_pkg::ORD_LEVEL, 3));
      dir.push_back(mk_req(ntt_pkg::CMD_TRAVERSE, 0, 0, ntt_pkg::ORD_LEVEL, 6'h3F));
      dir.push_back(mk_req(ntt_pkg::CMD_LEVEL, 8'hF0, 0, ntt_pkg::ORD_PRE, 0));
      r = mk_req(ntt_pkg::CMD_LEVEL, 0, 0, ntt_pkg::ORD_PRE, 0); r.has_rsp = 1;
      r.rsp = '{ntt_pkg::ST_NOT_FOUND, 0, 1, 6, 3, 3}; dir.push_back(r);
      r = mk_req(ntt_pkg::CMD_LEVEL, 8'h77, 0, ntt_pkg::ORD_PRE, 0); r.has_rsp = 1;
      r.rsp = '{ntt_pkg::ST_NOT_FOUND, 0, 1, 6, 3, 3}; dir.push_back(r);
      r = mk_req(ntt_pkg::CMD_CLEAR, 8'hFF, 6'h3F, ntt_pkg::ORD_LEVEL, 6'h3F);
      r.has_rsp = 1;
      r.rsp = '{ntt_pkg::ST_OK, 0, 1, 0, 0, 0}; dir.push_back(r);
      foreach (dir[k]) send_req(dir[k]);

      // a full table: a chain then a fan, then one too many, walks in all four orders and a level query
      for (i = 1; i <= ntt_pkg::MAX_NODES; i++)
         send_req(mk_req(ntt_pkg::CMD_INSERT, 8'(i), 6'(i < 20 ? i - 1 : 1),
                         ntt_pkg::ORD_PRE, 0));
      send_req(mk_req(ntt_pkg::CMD_INSERT, 8'h99, 1, ntt_pkg::ORD_PRE, 0));
      for (i = 0; i < 4; i++)
         send_req(mk_req(ntt_pkg::CMD_TRAVERSE, 0, 0, ntt_pkg::order_type'(i), 0));
      send_req(mk_req(ntt_pkg::CMD_LEVEL, 8'd19, 0, ntt_pkg::ORD_PRE, 0));
      drain_rsp();   // sender pauses until all responses are in
      send_req(mk_req(ntt_pkg::CMD_CLEAR, 0, 0, ntt_pkg::ORD_PRE, 0));

      for (i = 0; i < 390; i++) begin
         if (i == 130) begin
            send_idle_pct = 53; recv_idle_pct = 18;
         end
         if (i == 260) begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         send_req(rand_req());
      end
      drain_rsp();

      $display("covered %0d responses, %0d successful inserts, %0d walks of a tree",
               rsp_seen, inserts_ok, ok_walks);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> nary_tree_table_traversal_core.f
+incdir+hdl
hdl/ntt_pkg.sv
hdl/nary_tree_table_traversal_core.sv
dv/nary_tree_table_traversal_core_tb.sv
